// ===== hdl/dogx_pkg.sv =====
// Shared definitions for the DoG extremum detector.
// Register codes, reset values, field widths and default parameters.
// No dependencies.
package dogx_pkg;

   // Default module parameters
   localparam int MAX_WIDTH_DEFAULT   = 2048;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Geometry limits
   localparam int MIN_DIM    = 3;
   localparam int MAX_HEIGHT = 2048;

   // Field widths
   localparam int GEOM_BITS   = 12;
   localparam int THRESH_BITS = 15;
   localparam int POS_BITS    = 11;
   localparam int RESP_BITS   = 15;
   localparam int RESP_MAX    = 32767;

   // Result beat: row, col, response packed from bit 0, padded to bytes
   localparam int RSP_FIELD_BITS = 2 * POS_BITS + RESP_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Register reset values
   localparam logic [GEOM_BITS-1:0]   WIDTH_RESET     = 12'd640;
   localparam logic [GEOM_BITS-1:0]   HEIGHT_RESET    = 12'd480;
   localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 15'd328;

   // Register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_WIDTH        = 2'd0,
      REG_IMAGE_HEIGHT       = 2'd1,
      REG_CONTRAST_THRESHOLD = 2'd2
   } csr_reg_type;

endpackage

// ===== hdl/dog_extremum_detector_top.sv =====
// DoG extremum detector: 3x3x3 neighborhood test over a raster pixel stream.
// A pixel beat is captured in the input stage and tested there; a keypoint
// then loads the result register once that register is free.
// Throughput: one pixel per cycle; input stalls only while a keypoint waits
// behind a result beat that has not been taken.
// The line store is a single-port-read memory read at accept time.
// Reset (synchronous, active high) clears the counters, pipeline valids and
// configuration registers; the line store is not cleared and needs no clearing pass.
// Depends on dogx_pkg.
module dog_extremum_detector_top
   import dogx_pkg::*;
#(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // Pixel beat, fields from bit 0: sample_below, sample_centre, sample_above
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // Keypoint beat, fields from bit 0: row, col, response
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RSP_DATA_BITS-1:0]    rsp_tdata,
   // Configuration write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int SB     = SAMPLE_BITS;
   localparam int CELL_W = 3 * SB;
   localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int GW     = (CW + 1 > GEOM_BITS) ? CW + 1 : GEOM_BITS;
   localparam int MW     = (SB > THRESH_BITS) ? SB : THRESH_BITS;
   localparam int HW     = GEOM_BITS;

   typedef logic [CELL_W-1:0] cell_type;

   // Configuration registers
   logic [GEOM_BITS-1:0]   width_ff;
   logic [GEOM_BITS-1:0]   height_ff;
   logic [THRESH_BITS-1:0] thresh_ff;

   // Position counters
   logic [CW-1:0]       col_ff, col_in;
   logic [POS_BITS-1:0] row_ff, row_in;

   // Input stage
   logic                s1_valid_ff, s1_valid_in;
   cell_type            s1_cur_ff;
   logic [CW-1:0]       s1_col_ff;
   logic [POS_BITS-1:0] s1_row_ff;

   // Line store: word holds {row r-1, row r-2} of one column
   logic [2*CELL_W-1:0] line_mem [MAX_WIDTH];
   logic [2*CELL_W-1:0] rd_ff;
   cell_type            rd_top, rd_mid;

   // Window: columns c-2 and c-1, three rows each
   cell_type win_ff [6];

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic req_accept, csr_accept, advance, out_free;
   logic found;

   logic [GW-1:0] w_cfg, w_eff, col_cur, col_inc;
   logic [HW-1:0] h_eff, row_cur, row_inc;
   logic [CW-1:0] col_use;
   logic [POS_BITS-1:0] row_use;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid;
   assign req_accept = req_tvalid && req_tready;

   assign rd_top = rd_ff[CELL_W-1:0];
   assign rd_mid = rd_ff[2*CELL_W-1:CELL_W];

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thresh_ff <= THRESHOLD_RESET;
      end else if (csr_accept) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:        width_ff  <= csr_wdata[GEOM_BITS-1:0];
            REG_IMAGE_HEIGHT:       height_ff <= csr_wdata[GEOM_BITS-1:0];
            REG_CONTRAST_THRESHOLD: thresh_ff <= csr_wdata[THRESH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp geometry and step the raster position; a geometry write restarts it
   always_comb begin
      w_cfg = GW'(width_ff);
      if (w_cfg < GW'(MIN_DIM))        w_eff = GW'(MIN_DIM);
      else if (w_cfg > GW'(MAX_WIDTH)) w_eff = GW'(MAX_WIDTH);
      else                             w_eff = w_cfg;

      if (height_ff < HW'(MIN_DIM))         h_eff = HW'(MIN_DIM);
      else if (height_ff > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
      else                                  h_eff = height_ff;

      col_cur = (GW'(col_ff) >= w_eff) ? '0 : GW'(col_ff);
      row_cur = (HW'(row_ff) >= h_eff) ? '0 : HW'(row_ff);
      col_use = col_cur[CW-1:0];
      row_use = row_cur[POS_BITS-1:0];
      col_inc = col_cur + GW'(1);
      row_inc = row_cur + HW'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (csr_accept && (csr_index == REG_IMAGE_WIDTH ||
                         csr_index == REG_IMAGE_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_inc >= w_eff) begin
            col_in = '0;
            row_in = (row_inc >= h_eff) ? '0 : row_inc[POS_BITS-1:0];
         end else begin
            col_in = col_inc[CW-1:0];
            row_in = row_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Capture the accepted beat and its position
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cur_ff <= req_tdata[CELL_W-1:0];
         s1_col_ff <= col_use;
         s1_row_ff <= row_use;
      end
   end

   // Read the line store at accept, shift the column on advance
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ff <= line_mem[col_use];
      end
      if (advance) begin
         line_mem[s1_col_ff] <= {s1_cur_ff, rd_mid};
      end
   end

   // Slide the window by one column on advance
   always_ff @(posedge clock) begin
      if (advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= rd_top;
         win_ff[4] <= rd_mid;
         win_ff[5] <= s1_cur_ff;
      end
   end

   // Test the centre against threshold and its 26 neighbors
   always_comb begin
      cell_type             grid [9];
      logic [SB-1:0]        ctr_u;
      logic signed [SB-1:0] ctr_s;
      logic signed [SB-1:0] nb;
      logic [SB-1:0]        mag;
      logic [MW-1:0]        mag_w;
      logic [RESP_BITS-1:0] resp;
      logic                 is_max, is_min;

      grid[0] = win_ff[0];
      grid[1] = win_ff[1];
      grid[2] = win_ff[2];
      grid[3] = win_ff[3];
      grid[4] = win_ff[4];
      grid[5] = win_ff[5];
      grid[6] = rd_top;
      grid[7] = rd_mid;
      grid[8] = s1_cur_ff;

      ctr_u = grid[4][SB +: SB];
      ctr_s = $signed(ctr_u);
      mag   = ctr_u[SB-1] ? SB'(~ctr_u + SB'(1)) : ctr_u;
      mag_w = MW'(mag);

      is_max = 1'b1;
      is_min = 1'b1;
      for (int g = 0; g < 9; g++) begin
         for (int k = 0; k < 3; k++) begin
            nb = $signed(grid[g][k*SB +: SB]);
            if (!(g == 4 && k == 1)) begin
               if (ctr_s <= nb) is_max = 1'b0;
               if (ctr_s >= nb) is_min = 1'b0;
            end
         end
      end

      found = (s1_row_ff >= POS_BITS'(2)) && (s1_col_ff >= CW'(2)) &&
              (mag_w >= MW'(thresh_ff)) && (is_max || is_min);

      resp = (mag_w > MW'(RESP_MAX)) ? RESP_BITS'(RESP_MAX) : mag_w[RESP_BITS-1:0];

      rsp_data_in = RSP_DATA_BITS'({resp,
                                    POS_BITS'(s1_col_ff - CW'(1)),
                                    s1_row_ff - POS_BITS'(1)});
   end

   // Pipeline handshake: drop non-keypoints, hold while the result stalls
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && (!found || out_free);
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance)    s1_valid_in = 1'b0;
      if (req_accept) s1_valid_in = 1'b1;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready)      rsp_valid_in = 1'b0;
      if (advance && found) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result beat
   always_ff @(posedge clock) begin
      if (advance && found) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/dogx_checker.sv =====
// Port-level checks for the DoG extremum detector, bound to its top level.
// Depends on dogx_pkg and dog_extremum_detector_top.
module dogx_checker
   import dogx_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // Reset empties the result register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");

   // A stalled result beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // Only interior rows are reported
   a_row_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[POS_BITS-1:0] != '0 &&
                     rsp_tdata[POS_BITS-1:0] != {POS_BITS{1'b1}})
      else $error("keypoint row on the frame border");

   // No result can appear right after reset
   a_no_rise_after_reset: assert property (@(posedge clock)
      $rose(rsp_tvalid) |-> !$past(reset))
      else $error("result beat rose straight out of reset");

endmodule

bind dog_extremum_detector_top dogx_checker u_dogx_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
